@@ src/cmld_pkg.sv @@
// Shared types and constants for the COO merge / Laplacian diagonal unit.
package cmld_pkg;

	localparam int ROW_W    = 32;
	localparam int COL_W    = 32;
	localparam int WEIGHT_W = 24;
	localparam int OWNER_W  = 16;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = COL_W + VALUE_W + OWNER_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd1;

	localparam logic [CFG_DATA_W-1:0] VERTEX_COUNT_RESET = 7'd8;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_DIAG  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [ROW_W-1:0]           row_id;
		logic [COL_W-1:0]           col_id;
		logic signed [WEIGHT_W-1:0] weight;
		logic [OWNER_W-1:0]         owner;
		logic                       end_of_stream;
	} entry_t;

	typedef struct packed {
		logic [ROW_W-1:0]          out_row;
		logic [COL_W-1:0]          out_col;
		logic signed [VALUE_W-1:0] out_value;
		logic [OWNER_W-1:0]        out_owner;
		logic [STATUS_W-1:0]       status;
		logic                      row_last;
		logic                      stream_last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch the accepted entry
		logic update;      // merge or store the latched entry
		logic drain_init;  // restart the drain index
		logic rd;          // issue buffer read at the drain index
		logic load;        // move read data into the output register
		logic clear;       // close the open row
		logic stream_end;  // drain belongs to the end of the stream
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flush_old;   // latched entry starts a new row while one is open
		logic eos;         // latched entry ends the stream
		logic last_entry;  // drain index is on the final buffered entry
		logic out_free;    // output register can take a value
	} dp_status_t;

endpackage

@@ src/cmld_if.sv @@
// Channel interfaces: entry input, result output and configuration write.
interface cmld_entry_if;
	logic              valid;
	logic              ready;
	cmld_pkg::entry_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface cmld_result_if;
	logic              valid;
	logic              ready;
	cmld_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface cmld_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cmld_pkg::CFG_IDX_W-1:0]  index;
	logic [cmld_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/coo_merge_laplacian_diag_unit.sv @@
// Top level: COO duplicate merge with graph-Laplacian diagonal rewrite.
//
//  channel   dir  handshake      payload
//  entries   in   valid/ready    row_id, col_id, weight, owner, end_of_stream
//  results   out  valid/ready    out_row, out_col, out_value, out_owner, status,
//                                row_last, stream_last
//  cfg       in   valid/ready    index (0 weighted_mode, 1 vertex_count), data
//
// An entry is captured, then merged or stored into the row buffer.
// A row drain takes each buffered entry through the buffer RAM's registered
// read, then the load into the output register; a stalled output holds the drain.
// Entries are refused while a row drains; cfg is always ready.
// Reset clears row state and returns configuration to its defaults; the buffer RAM itself is not cleared.
module coo_merge_laplacian_diag_unit #(
	parameter int ROW_MAX = 32
) (
	input logic          clk,
	input logic          arst_n,
	cmld_entry_if.sink   entries,
	cmld_result_if.source results,
	cmld_cfg_if.sink     cfg
);

	cmld_pkg::ctrl_cmd_t  cmd;
	cmld_pkg::dp_status_t st;
	logic                 in_ready;

	assign entries.ready = in_ready;
	assign cfg.ready     = 1'b1;

	cmld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (entries.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	cmld_datapath #(
		.ROW_MAX (ROW_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (entries.payload),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.result    (results.payload)
	);

endmodule

@@ src/cmld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cmld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/cmld_ctrl.sv @@
// Controller: sequences entry capture, row update and row drain.
module cmld_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cmld_pkg::dp_status_t st,
	output cmld_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_UPDATE   = 4'b0010,
		S_DRAIN_RD = 4'b0100,
		S_DRAIN_LD = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   eos_phase_q, eos_phase_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		eos_phase_d    = eos_phase_q;
		cmd            = '0;
		cmd.stream_end = eos_phase_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (st.flush_old) begin
					// old row goes out first, entry is applied afterwards
					cmd.drain_init = 1'b1;
					eos_phase_d    = 1'b0;
					state_d        = S_DRAIN_RD;
				end else begin
					cmd.update = 1'b1;
					if (st.eos) begin
						cmd.drain_init = 1'b1;
						eos_phase_d    = 1'b1;
						state_d        = S_DRAIN_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DRAIN_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_DRAIN_LD;
			end
			S_DRAIN_LD: begin
				if (st.out_free) begin
					cmd.load = 1'b1;
					if (st.last_entry) begin
						cmd.clear = 1'b1;
						state_d   = eos_phase_q ? S_IDLE : S_UPDATE;
					end else begin
						state_d = S_DRAIN_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			eos_phase_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			eos_phase_q <= eos_phase_d;
		end
	end

endmodule

@@ src/cmld_datapath.sv @@
// Datapath: entry register, row state, row buffer, diagonal and output register.
module cmld_datapath #(
	parameter int ROW_MAX = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cmld_pkg::entry_t                    entry,
	input  logic                                cfg_valid,
	input  logic [cmld_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmld_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  cmld_pkg::ctrl_cmd_t                 cmd,
	output cmld_pkg::dp_status_t                st,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cmld_pkg::result_t                   result
);

	localparam int IDX_W = $clog2(ROW_MAX);
	localparam int CNT_W = $clog2(ROW_MAX + 1);
	localparam logic [CNT_W-1:0] NO_DIAG   = '1;
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(ROW_MAX);
	localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// configuration
	logic                              wmode_q;
	logic [cmld_pkg::CFG_DATA_W-1:0]   vcount_q;

	// latched entry
	cmld_pkg::entry_t                  item_q;

	// open row state
	logic [cmld_pkg::ROW_W-1:0]        open_row_q;
	logic                              open_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  diag_q;
	logic signed [31:0]                sum_q;
	logic                              ovf_q;
	logic [cmld_pkg::COL_W-1:0]        last_col_q;
	logic signed [31:0]                last_val_q;
	logic [cmld_pkg::OWNER_W-1:0]      last_own_q;

	// drain
	logic [CNT_W-1:0]                  k_q;
	logic                              out_valid_q;
	cmld_pkg::result_t                 out_q;

	// buffer
	logic                              ram_we;
	logic [IDX_W-1:0]                  ram_waddr;
	logic [cmld_pkg::WORD_W-1:0]       ram_wdata;
	logic [cmld_pkg::WORD_W-1:0]       ram_rdata;

	logic signed [31:0]                w32;
	logic [cmld_pkg::ROW_W-1:0]        cur_row;
	logic                              merge;
	logic signed [31:0]                merged_val;
	logic signed [31:0]                sum_next;
	logic signed [31:0]                dval;
	logic [cmld_pkg::STATUS_W-1:0]     row_status;
	logic [CNT_W-1:0]                  k_inc;
	logic [cmld_pkg::COL_W-1:0]        rd_col;
	logic signed [31:0]                rd_val;
	logic [cmld_pkg::OWNER_W-1:0]      rd_own;

	assign w32        = {{(32 - cmld_pkg::WEIGHT_W){item_q.weight[cmld_pkg::WEIGHT_W-1]}},
	                     item_q.weight};
	assign cur_row    = open_q ? open_row_q : item_q.row_id;
	assign merge      = (count_q != '0) && (item_q.col_id == last_col_q);
	assign merged_val = sat34({{2{last_val_q[31]}}, last_val_q} + {{2{w32[31]}}, w32});
	assign sum_next   = sat34({{2{sum_q[31]}}, sum_q} + {{2{w32[31]}}, w32});

	// diagonal value and row status, stable while the row drains
	always_comb begin
		if (wmode_q) begin
			dval = sat34(34'sd0 - $signed({27'd0, vcount_q}) - {{2{sum_q[31]}}, sum_q});
		end else begin
			dval = $signed(32'(count_q)) - 32'sd1;
		end
		if (ovf_q) begin
			row_status = cmld_pkg::STATUS_OVERFLOW;
		end else if (diag_q == NO_DIAG) begin
			row_status = cmld_pkg::STATUS_NO_DIAG;
		end else begin
			row_status = cmld_pkg::STATUS_OK;
		end
	end

	// buffer write: weighted merge to the last slot, new column to the next one
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = {item_q.col_id, w32, item_q.owner};
		if (cmd.update) begin
			if (merge) begin
				ram_we    = wmode_q;
				ram_waddr = IDX_W'(count_q - CNT_W'(1));
				ram_wdata = {last_col_q, merged_val, last_own_q};
			end else if (count_q < CNT_MAX) begin
				ram_we = 1'b1;
			end
		end
	end

	cmld_ram #(
		.WIDTH (cmld_pkg::WORD_W),
		.DEPTH (ROW_MAX)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (k_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_col = ram_rdata[cmld_pkg::WORD_W-1 -: cmld_pkg::COL_W];
	assign rd_val = ram_rdata[cmld_pkg::VALUE_W + cmld_pkg::OWNER_W - 1 -: cmld_pkg::VALUE_W];
	assign rd_own = ram_rdata[cmld_pkg::OWNER_W-1:0];
	assign k_inc  = k_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmode_q  <= 1'b0;
			vcount_q <= cmld_pkg::VERTEX_COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				cmld_pkg::REG_WEIGHTED_MODE: wmode_q  <= cfg_data[0];
				cmld_pkg::REG_VERTEX_COUNT:  vcount_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= entry;
		end
		if (cmd.update) begin
			if (merge) begin
				if (wmode_q) begin
					last_val_q <= merged_val;
				end
			end else if (count_q < CNT_MAX) begin
				last_col_q <= item_q.col_id;
				last_val_q <= w32;
				last_own_q <= item_q.owner;
			end
		end
		if (cmd.load) begin
			out_q.out_row     <= open_row_q;
			out_q.out_col     <= rd_col;
			out_q.out_value   <= (k_q == diag_q) ? dval : rd_val;
			out_q.out_owner   <= rd_own;
			out_q.status      <= row_status;
			out_q.row_last    <= st.last_entry;
			out_q.stream_last <= st.last_entry & cmd.stream_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_row_q  <= '0;
			open_q      <= 1'b0;
			count_q     <= '0;
			diag_q      <= NO_DIAG;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				open_q     <= 1'b1;
				open_row_q <= cur_row;
				if (merge) begin
					if (wmode_q) begin
						sum_q <= sum_next;
					end
				end else if (count_q < CNT_MAX) begin
					if (item_q.col_id == cur_row) begin
						diag_q <= count_q;
					end
					count_q <= count_q + CNT_W'(1);
					sum_q   <= sum_next;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.drain_init) begin
				k_q <= '0;
			end else if (cmd.load) begin
				k_q <= k_inc;
			end
			if (cmd.clear) begin
				open_q  <= 1'b0;
				count_q <= '0;
				diag_q  <= NO_DIAG;
				sum_q   <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.flush_old  = open_q && (count_q != '0) && (item_q.row_id != open_row_q);
	assign st.eos        = item_q.end_of_stream;
	assign st.last_entry = (k_inc == count_q);
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule
